[rtl/knapsack_dp_engine_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the knapsack DP engine
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef KNAPSACK_DP_ENGINE_CORE_ASSERT_SVH
`define KNAPSACK_DP_ENGINE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KDE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KDE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/kde_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kde_pkg
// Constants, types and helper functions of the knapsack DP engine.
// ----------------------------------------------------------------------------
package kde_pkg;

   localparam int CAPACITY_LIMIT = 1023;
   localparam int SUM_BITS       = 32;
   localparam int ROW_DEPTH      = CAPACITY_LIMIT + 1;
   localparam int ROW_AW         = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;

   localparam int VALUE_BITS  = 16;
   localparam int WEIGHT_BITS = 16;
   localparam int CAP_BITS    = 10;
   localparam int OUT_BITS    = 32;

   localparam int SUM_WIDE  = ((SUM_BITS > VALUE_BITS) ? SUM_BITS : VALUE_BITS) + 1;
   localparam int WIDE_BITS = (SUM_BITS > OUT_BITS) ? SUM_BITS : OUT_BITS;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(1023);

   // register index decoded from paddr[2]
   localparam logic REG_CAPACITY = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_READ,
      ST_CAPTURE
   } state_type;

   typedef struct packed {
      logic load_item;
      logic sweep_step;
      logic clear_step;
      logic read_cap;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic fits;
      logic sweep_end;
      logic clear_end;
   } status_type;

   function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] entry,
                                                   input logic [VALUE_BITS-1:0] value);
      logic [SUM_WIDE-1:0] sum;
      sum = SUM_WIDE'(entry) + SUM_WIDE'(value);
      if (sum > SUM_WIDE'({SUM_BITS{1'b1}})) begin
         return {SUM_BITS{1'b1}};
      end
      return sum[SUM_BITS-1:0];
   endfunction

   function automatic logic [OUT_BITS-1:0] sat_out(input logic [SUM_BITS-1:0] entry);
      logic [WIDE_BITS-1:0] wide;
      wide = WIDE_BITS'(entry);
      if (wide > WIDE_BITS'({OUT_BITS{1'b1}})) begin
         return {OUT_BITS{1'b1}};
      end
      return wide[OUT_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

[rtl/kde_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kde_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module kde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   output      logic [WIDTH-1:0]                        rd_data_a,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output      logic [WIDTH-1:0]                        rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule
`default_nettype wire

[rtl/kde_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kde_ctrl
// Sequencer: row clear, per-item capacity sweep, result read and handoff.
// ----------------------------------------------------------------------------
module kde_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_last_item,
   output      logic                req_ready,
   input  wire logic                rsp_ready,
   output      logic                rsp_valid,
   input  wire kde_pkg::status_type status,
   output      kde_pkg::cmd_type    cmd
);

   kde_pkg::state_type state_ff;
   kde_pkg::state_type state_in;
   logic               last_ff;
   logic               last_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kde_pkg::ST_CLEAR;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      last_in   = last_ff;
      cmd       = '0;
      req_ready = 1'b0;
      out_free  = !rsp_valid_ff || rsp_ready;

      unique case (state_ff)
         kde_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_end) begin
               state_in = kde_pkg::ST_IDLE;
            end
         end
         kde_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               last_in       = req_last_item;
               state_in      = kde_pkg::ST_SWEEP;
            end
         end
         kde_pkg::ST_SWEEP: begin
            // an item heavier than the row changes nothing
            if (!status.fits) begin
               state_in = last_ff ? kde_pkg::ST_READ : kde_pkg::ST_IDLE;
            end else begin
               cmd.sweep_step = 1'b1;
               if (status.sweep_end) begin
                  state_in = kde_pkg::ST_DRAIN;
               end
            end
         end
         kde_pkg::ST_DRAIN: begin
            // final write of the sweep lands here
            state_in = last_ff ? kde_pkg::ST_READ : kde_pkg::ST_IDLE;
         end
         kde_pkg::ST_READ: begin
            cmd.read_cap = 1'b1;
            state_in     = kde_pkg::ST_CAPTURE;
         end
         kde_pkg::ST_CAPTURE: begin
            cmd.read_cap = 1'b1;
            // hold the read until the output register is free
            if (out_free) begin
               cmd.load_result = 1'b1;
               state_in        = kde_pkg::ST_CLEAR;
            end
         end
         default: begin
            state_in = kde_pkg::ST_CLEAR;
         end
      endcase

      priority if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[rtl/kde_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kde_datapath
// Best-value row memory, sweep address counter, saturating add and compare.
// ----------------------------------------------------------------------------
module kde_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire kde_pkg::cmd_type                   cmd,
   input  wire logic [kde_pkg::CAP_BITS-1:0]       capacity,
   input  wire logic [kde_pkg::VALUE_BITS-1:0]     req_item_value,
   input  wire logic [kde_pkg::WEIGHT_BITS-1:0]    req_item_weight,
   output      kde_pkg::status_type                status,
   output      logic [kde_pkg::OUT_BITS-1:0]       rsp_best_value
);

   logic [kde_pkg::VALUE_BITS-1:0]  value_ff;
   logic [kde_pkg::VALUE_BITS-1:0]  value_in;
   logic [kde_pkg::WEIGHT_BITS-1:0] weight_ff;
   logic [kde_pkg::WEIGHT_BITS-1:0] weight_in;
   logic [kde_pkg::ROW_AW-1:0]      addr_ff;
   logic [kde_pkg::ROW_AW-1:0]      addr_in;
   logic                            wr_pend_ff;
   logic                            wr_pend_in;
   logic [kde_pkg::ROW_AW-1:0]      wr_addr_ff;
   logic [kde_pkg::ROW_AW-1:0]      wr_addr_in;
   logic [kde_pkg::OUT_BITS-1:0]    best_ff;
   logic [kde_pkg::OUT_BITS-1:0]    best_in;

   logic [kde_pkg::ROW_AW-1:0]      weight_addr;
   logic [kde_pkg::ROW_AW-1:0]      cap_addr;
   logic [kde_pkg::ROW_AW-1:0]      rd_addr_a;
   logic [kde_pkg::ROW_AW-1:0]      rd_addr_b;
   logic [kde_pkg::SUM_BITS-1:0]    rd_data_a;
   logic [kde_pkg::SUM_BITS-1:0]    rd_data_b;
   logic [kde_pkg::SUM_BITS-1:0]    cand;
   logic [kde_pkg::SUM_BITS-1:0]    merged;
   logic                            wr_en;
   logic [kde_pkg::ROW_AW-1:0]      wr_addr;
   logic [kde_pkg::SUM_BITS-1:0]    wr_data;

   kde_ram #(
      .WIDTH (kde_pkg::SUM_BITS),
      .DEPTH (kde_pkg::ROW_DEPTH)
   ) u_row (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff    <= kde_pkg::ROW_AW'(kde_pkg::CAPACITY_LIMIT);
         wr_pend_ff <= 1'b0;
      end else begin
         addr_ff    <= addr_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      weight_ff  <= weight_in;
      wr_addr_ff <= wr_addr_in;
      best_ff    <= best_in;
   end

   always_comb begin
      weight_addr      = kde_pkg::ROW_AW'(weight_ff);
      status.fits      = 32'(weight_ff) < 32'(kde_pkg::ROW_DEPTH);
      status.sweep_end = (addr_ff == weight_addr);
      status.clear_end = (addr_ff == '0);

      if (32'(capacity) > 32'(kde_pkg::CAPACITY_LIMIT)) begin
         cap_addr = kde_pkg::ROW_AW'(kde_pkg::CAPACITY_LIMIT);
      end else begin
         cap_addr = kde_pkg::ROW_AW'(capacity);
      end

      // port A: entry being updated (or the result entry), port B: entry one weight below
      rd_addr_a = cmd.read_cap ? cap_addr : addr_ff;
      rd_addr_b = addr_ff - weight_addr;

      cand   = kde_pkg::sat_add(rd_data_b, value_ff);
      merged = (cand > rd_data_a) ? cand : rd_data_a;

      wr_en   = wr_pend_ff || cmd.clear_step;
      wr_addr = cmd.clear_step ? addr_ff : wr_addr_ff;
      wr_data = cmd.clear_step ? '0 : merged;

      wr_pend_in = cmd.sweep_step;
      wr_addr_in = addr_ff;

      priority if (cmd.load_item || cmd.load_result) begin
         addr_in = kde_pkg::ROW_AW'(kde_pkg::CAPACITY_LIMIT);
      end else if (cmd.sweep_step || cmd.clear_step) begin
         addr_in = addr_ff - kde_pkg::ROW_AW'(1);
      end else begin
         addr_in = addr_ff;
      end

      value_in  = cmd.load_item ? req_item_value : value_ff;
      weight_in = cmd.load_item ? req_item_weight : weight_ff;
      best_in   = cmd.load_result ? kde_pkg::sat_out(rd_data_a) : best_ff;
   end

   assign rsp_best_value = best_ff;

endmodule
`default_nettype wire

[rtl/knapsack_dp_engine_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knapsack_dp_engine_core
// 0/1 knapsack solver over one row of best values, one entry per capacity.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one knapsack item (value, weight, last flag) per valid/ready
//   handshake. rsp_* carries one result, the best value at the configured
//   capacity, after each item flagged last. The capacity register sits at
//   byte address 0 of the APB-style port, and the user must see that it is
//   written only while idle; the block itself does not enforce this. An item
//   of weight w below 1024 is swept one row entry per cycle, bounded by the
//   row RAM's single write port; a heavier item leaves the row unchanged. A
//   last item then has its result entry read, and a pass zeroes all 1024 row
//   entries before the next item is taken. After reset the same clearing pass
//   runs before req_ready rises; configuration writes are taken throughout.
//   A result waits in the output register while the receiver stalls; the
//   block keeps sweeping new items meanwhile, and stalls only when a second
//   result is ready before the first is taken.
// ----------------------------------------------------------------------------
`include "knapsack_dp_engine_core_assert.svh"

module knapsack_dp_engine_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic [kde_pkg::VALUE_BITS-1:0]   req_item_value,
   input  wire logic [kde_pkg::WEIGHT_BITS-1:0]  req_item_weight,
   input  wire logic                             req_last_item,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [kde_pkg::OUT_BITS-1:0]     rsp_best_value,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [kde_pkg::CSR_AW-1:0]       paddr,
   input  wire logic [kde_pkg::CSR_DW-1:0]       pwdata,
   output      logic [kde_pkg::CSR_DW-1:0]       prdata,
   output      logic                             pready
);

   logic [kde_pkg::CAP_BITS-1:0] capacity_ff;
   logic [kde_pkg::CAP_BITS-1:0] capacity_in;
   logic                         csr_write;
   logic                         csr_hit;
   kde_pkg::cmd_type             cmd;
   kde_pkg::status_type          status;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= kde_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      pready      = 1'b1;
      csr_hit     = (paddr[2] == kde_pkg::REG_CAPACITY);
      csr_write   = psel && penable && pwrite && pready;
      capacity_in = (csr_write && csr_hit) ? pwdata[kde_pkg::CAP_BITS-1:0] : capacity_ff;
      prdata      = csr_hit ? kde_pkg::CSR_DW'(capacity_ff) : '0;
   end

   kde_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_last_item),
      .req_ready     (req_ready),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .status        (status),
      .cmd           (cmd)
   );

   kde_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .capacity        (capacity_ff),
      .req_item_value  (req_item_value),
      .req_item_weight (req_item_weight),
      .status          (status),
      .rsp_best_value  (rsp_best_value)
   );

   `KDE_ASSERT_SAME(a_no_accept_in_sweep, req_ready, !cmd.sweep_step && !cmd.clear_step, "item accepted while the row is busy")
   `KDE_ASSERT_SAME(a_no_result_overwrite, cmd.load_result, !rsp_valid || rsp_ready, "pending result overwritten")
   `KDE_ASSERT_SAME(a_one_row_writer, cmd.clear_step, !cmd.sweep_step && !cmd.read_cap, "clear overlaps a sweep or result read")
   `KDE_ASSERT_NEXT(a_result_shows, cmd.load_result, rsp_valid, "loaded result not presented")

endmodule
`default_nettype wire
